// File: rtl/scfc_pkg.sv
// ----------------------------------------------------------------------------
// scfc_pkg
// Shared constants for the stepper command frame controller: event codes,
// frame layout, command codes, speed limits and reset values.
// ----------------------------------------------------------------------------
package scfc_pkg;

   // frame store geometry (supported range 10..64 entries)
   localparam int FRAME_DEPTH = 16;
   localparam int FILL_W      = $clog2(FRAME_DEPTH + 1);
   localparam int IDX_W       = $clog2(FRAME_DEPTH);

   // event codes
   localparam logic [1:0] OP_RX_BYTE = 2'd0;
   localparam logic [1:0] OP_MS_TICK = 2'd1;
   localparam logic [1:0] OP_STEP_TICK = 2'd2;

   // frame header
   localparam logic [7:0] HDR0 = 8'h30;
   localparam logic [7:0] HDR1 = 8'hFF;

   // command codes
   localparam logic [7:0] CMD_SET_TARGET = 8'h00;
   localparam logic [7:0] CMD_RUN        = 8'h01;
   localparam logic [7:0] CMD_STOP       = 8'h02;
   localparam logic [7:0] CMD_QUERY      = 8'h03;

   // speed clamp, in step-delay ticks
   localparam logic [6:0] SPEED_MIN = 7'd2;
   localparam logic [6:0] SPEED_MAX = 7'd80;

   // reset values
   localparam logic [15:0] IDLE_LIMIT_RST = 16'd20;
   localparam logic [31:0] TARGET_RST     = 32'd50000;
   localparam logic [6:0]  SPEED_RST      = 7'd40;

endpackage

// File: rtl/stepper_command_frame_controller.sv
// ----------------------------------------------------------------------------
// stepper_command_frame_controller
// Step/direction stepper controller driven by framed serial command bytes,
// millisecond ticks and step-delay ticks.
// ----------------------------------------------------------------------------
// Each request beat is one event. The block takes one beat per clock while
// the response is not stalled. A beat is held in an input register, then a
// single pass of logic updates the frame store, idle counter and motion
// state, which with the report flag form the response register. The input
// register takes a new beat while the response waits only if it is empty.
// Received bytes fill a 16-entry frame store; once the line has been silent
// for more than idle_limit millisecond ticks the frame is decoded (header
// 0x30 0xFF, then a command byte). A stalled response holds both the result
// and all state updates.
module stepper_command_frame_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pulse_level,
   output logic        rsp_direction,
   output logic        rsp_moving,
   output logic [31:0] rsp_position,
   output logic [31:0] rsp_step_target,
   output logic        rsp_status_report,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int FILL_W_C = scfc_pkg::FILL_W;
   localparam int IDX_W_C  = scfc_pkg::IDX_W;

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_op_ff;
   logic [7:0]  in_byte_ff;

   // response / state registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic        report_ff, report_in;
   logic [15:0] idle_limit_ff;
   logic [FILL_W_C-1:0] fill_ff, fill_in;
   logic [15:0] idle_ff, idle_in;
   logic [31:0] target_ff, target_in;
   logic [31:0] done_ff, done_in;
   logic [31:0] pos_ff, pos_in;
   logic [6:0]  speed_ff, speed_in;
   logic [6:0]  delay_ff, delay_in;
   logic        dir_ff, dir_in;
   logic        moving_ff, moving_in;
   logic        pulse_ff, pulse_in;

   logic [7:0] frame_mem [scfc_pkg::FRAME_DEPTH];

   logic        advance;
   logic        store_wr;
   logic [16:0] idle_next;
   logic [15:0] spd_raw;
   logic [6:0]  spd_clamped;
   logic [6:0]  delay_next;
   logic [31:0] done_next;
   logic        hdr_ok;

   // handshake
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_pulse_level   = pulse_ff;
   assign rsp_direction     = dir_ff;
   assign rsp_moving        = moving_ff;
   assign rsp_position      = pos_ff;
   assign rsp_step_target   = target_ff;
   assign rsp_status_report = report_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff   <= req_opcode;
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame store write, no reset
   assign store_wr = in_valid_ff && advance && (in_op_ff == scfc_pkg::OP_RX_BYTE)
                     && (fill_ff < FILL_W_C'(scfc_pkg::FRAME_DEPTH));

   always_ff @(posedge clock) begin
      if (store_wr) begin
         frame_mem[fill_ff[IDX_W_C-1:0]] <= in_byte_ff;
      end
   end

   // decode helpers
   assign hdr_ok  = (frame_mem[0] == scfc_pkg::HDR0) && (frame_mem[1] == scfc_pkg::HDR1);
   assign spd_raw = {frame_mem[4], frame_mem[5]};

   always_comb begin
      if (spd_raw > 16'(scfc_pkg::SPEED_MAX)) begin
         spd_clamped = scfc_pkg::SPEED_MAX;
      end else if (spd_raw < 16'(scfc_pkg::SPEED_MIN)) begin
         spd_clamped = scfc_pkg::SPEED_MIN;
      end else begin
         spd_clamped = spd_raw[6:0];
      end
   end

   assign idle_next  = {1'b0, idle_ff} + 17'd1;
   assign delay_next = delay_ff + 7'd1;
   assign done_next  = done_ff + 32'd1;

   // next state for one event
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      report_in    = report_ff;
      fill_in      = fill_ff;
      idle_in      = idle_ff;
      target_in    = target_ff;
      done_in      = done_ff;
      pos_in       = pos_ff;
      speed_in     = speed_ff;
      delay_in     = delay_ff;
      dir_in       = dir_ff;
      moving_in    = moving_ff;
      pulse_in     = pulse_ff;

      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end

      if (in_valid_ff && advance) begin
         report_in = 1'b0;
         case (in_op_ff)
            scfc_pkg::OP_RX_BYTE: begin
               idle_in = '0;
               if (fill_ff < FILL_W_C'(scfc_pkg::FRAME_DEPTH)) begin
                  fill_in = fill_ff + FILL_W_C'(1);
               end
            end
            scfc_pkg::OP_MS_TICK: begin
               if (fill_ff != '0) begin
                  if (idle_next > {1'b0, idle_limit_ff}) begin
                     // line silent long enough: decode and empty the store
                     idle_in = '0;
                     fill_in = '0;
                     if (hdr_ok) begin
                        case (frame_mem[2])
                           scfc_pkg::CMD_SET_TARGET: begin
                              target_in = {24'd0, frame_mem[3]};
                           end
                           scfc_pkg::CMD_RUN: begin
                              dir_in    = (frame_mem[3] != 8'd0);
                              speed_in  = spd_clamped;
                              target_in = {frame_mem[6], frame_mem[7],
                                           frame_mem[8], frame_mem[9]};
                              moving_in = 1'b1;
                           end
                           scfc_pkg::CMD_STOP: begin
                              moving_in = 1'b0;
                           end
                           scfc_pkg::CMD_QUERY: begin
                              report_in = 1'b1;
                           end
                           default: begin
                           end
                        endcase
                     end
                  end else begin
                     idle_in = idle_next[15:0];
                  end
               end
            end
            scfc_pkg::OP_STEP_TICK: begin
               if (moving_ff) begin
                  if (delay_next >= speed_ff) begin
                     // one step: toggle pulse and count it
                     delay_in = '0;
                     pulse_in = !pulse_ff;
                     pos_in   = pos_ff + 32'd1;
                     if (done_next >= target_ff) begin
                        done_in   = '0;
                        moving_in = 1'b0;
                     end else begin
                        done_in = done_next;
                     end
                  end else begin
                     delay_in = delay_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         report_ff     <= 1'b0;
         idle_limit_ff <= scfc_pkg::IDLE_LIMIT_RST;
         fill_ff       <= '0;
         idle_ff       <= '0;
         target_ff     <= scfc_pkg::TARGET_RST;
         done_ff       <= '0;
         pos_ff        <= '0;
         speed_ff      <= scfc_pkg::SPEED_RST;
         delay_ff      <= '0;
         dir_ff        <= 1'b0;
         moving_ff     <= 1'b0;
         pulse_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         report_ff    <= report_in;
         fill_ff      <= fill_in;
         idle_ff      <= idle_in;
         target_ff    <= target_in;
         done_ff      <= done_in;
         pos_ff       <= pos_in;
         speed_ff     <= speed_in;
         delay_ff     <= delay_in;
         dir_ff       <= dir_in;
         moving_ff    <= moving_in;
         pulse_ff     <= pulse_in;
         if (csr_wr_en) begin
            idle_limit_ff <= csr_wr_data;
         end
      end
   end

   // checks
   fill_bound_a: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W_C'(scfc_pkg::FRAME_DEPTH))
      else $error("frame fill past store depth");

   speed_range_a: assert property (@(posedge clock) disable iff (reset)
      (speed_ff >= scfc_pkg::SPEED_MIN) && (speed_ff <= scfc_pkg::SPEED_MAX))
      else $error("step speed outside clamp range");

   report_src_a: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && (in_op_ff != scfc_pkg::OP_MS_TICK)) |=> !report_ff)
      else $error("status report on a non-tick beat");

   pos_moves_a: assert property (@(posedge clock) disable iff (reset)
      !moving_ff |=> $stable(pos_ff))
      else $error("position changed while stopped");

   stall_hold_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(pos_ff) && $stable(target_ff)
                                       && $stable(moving_ff)))
      else $error("state changed under a stalled response");

endmodule
